/* rtl/dcs_pkg.sv */
// Shared types, constants and saturation helper for the density spline evaluator.
package dcs_pkg;

    localparam int DIST_W     = 20;   // Q4.16 distance
    localparam int WORD_W     = 32;   // write data and Q8.24 coefficients
    localparam int OUT_W      = 32;   // Q8.24 results
    localparam int ACC_W      = 40;   // Q16.24 Horner accumulator
    localparam int DX_W       = DIST_W + 1;
    localparam int FRAC_SHIFT = 16;
    localparam int ROUND_HALF = 1 << (FRAC_SHIFT - 1);
    localparam int CFG_IDX_W  = 3;

    localparam logic [DIST_W-1:0]        INNER_START_RST   = 20'd132448;
    localparam logic [DIST_W-1:0]        LINEAR_START_RST  = 20'd59014;
    localparam logic [DIST_W-1:0]        CUTOFF_RST        = 20'd364249;
    localparam logic signed [WORD_W-1:0] LINEAR_SLOPE_RST  = 32'sd1308623;
    localparam logic signed [WORD_W-1:0] LINEAR_OFFSET_RST = 32'sd1466329;

    typedef enum logic {
        CMD_EVAL  = 1'b0,
        CMD_WRITE = 1'b1
    } t_cmd;

    typedef enum logic [2:0] {
        WSEL_KNOT = 3'd0,
        WSEL_A    = 3'd1,
        WSEL_B    = 3'd2,
        WSEL_C    = 3'd3,
        WSEL_D    = 3'd4
    } t_word_sel;

    typedef enum logic [1:0] {
        REGION_BELOW  = 2'd0,
        REGION_LINEAR = 2'd1,
        REGION_SPLINE = 2'd2,
        REGION_BEYOND = 2'd3
    } t_region;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INNER_START   = 3'd0,
        CFG_LINEAR_START  = 3'd1,
        CFG_CUTOFF        = 3'd2,
        CFG_LINEAR_SLOPE  = 3'd3,
        CFG_LINEAR_OFFSET = 3'd4
    } t_cfg_idx;

    // Clamp a Q16.24 accumulator to the 32 bit result range.
    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [ACC_W-1:0] v);
        logic [ACC_W-OUT_W:0] top;
        top = v[ACC_W-1:OUT_W-1];
        if (top == '0 || top == '1) begin
            return v[OUT_W-1:0];
        end else if (v[ACC_W-1]) begin
            return {1'b1, {(OUT_W-1){1'b0}}};
        end else begin
            return {1'b0, {(OUT_W-1){1'b1}}};
        end
    endfunction

endpackage

/* rtl/dcs_horner_step.sv */
// One Horner step: registered multiply, then rounded add and 40 bit clamp.
module dcs_horner_step
    import dcs_pkg::*;
#(
    parameter int T_W = 40,
    parameter int C_W = 32
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic signed [T_W-1:0]   i_t,
    input  logic signed [C_W-1:0]   i_coef,
    input  logic signed [DX_W-1:0]  i_dx,
    output logic signed [ACC_W-1:0] o_sum
);

    localparam int P_W = T_W + DX_W;
    localparam int S_W = P_W + 2;

    logic signed [P_W-1:0]   r_prod;
    logic signed [C_W-1:0]   r_coef;
    logic signed [ACC_W-1:0] r_sum;
    logic signed [S_W-1:0]   n_round;
    logic signed [S_W-1:0]   n_total;
    logic signed [ACC_W-1:0] n_sum;
    logic [S_W-ACC_W:0]      top;

    // Round half up, add the coefficient, clamp to Q16.24
    always_comb begin
        n_round = (S_W'(r_prod) + S_W'(ROUND_HALF)) >>> FRAC_SHIFT;
        n_total = n_round + S_W'(r_coef);
        top     = n_total[S_W-1:ACC_W-1];
        if (top == '0 || top == '1) begin
            n_sum = n_total[ACC_W-1:0];
        end else if (n_total[S_W-1]) begin
            n_sum = {1'b1, {(ACC_W-1){1'b0}}};
        end else begin
            n_sum = {1'b0, {(ACC_W-1){1'b1}}};
        end
    end

    // Advance both stages together with the pipeline
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= P_W'(i_t) * P_W'(i_dx);
            r_coef <= i_coef;
            r_sum  <= n_sum;
        end
    end

    assign o_sum = r_sum;

endmodule

/* rtl/density_cubic_spline_eval.sv */
// Throughput: one transaction per cycle unless the output stalls; the knot search, the
// coefficient RAM read and the three chained Horner steps of the density (multiply stage
// plus round/clamp stage each) set the depth. A stall on the output holds the whole pipeline.
// Table writes are applied from the stage 0 register.
// Reset clears valid bits and loads the configuration defaults; knot and coefficient
// tables hold garbage until written.
module density_cubic_spline_eval
    import dcs_pkg::*;
#(
    parameter int KNOTS     = 15,
    parameter int COEF_BITS = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // configuration
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [WORD_W-1:0]          i_cfg_data,
    // input channel
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic                       i_cmd,
    input  logic [DIST_W-1:0]          i_distance,
    input  logic [$clog2(KNOTS)-1:0]   i_table_index,
    input  logic [2:0]                 i_word_select,
    input  logic signed [WORD_W-1:0]   i_word_value,
    // output channel
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic signed [OUT_W-1:0]    o_density,
    output logic signed [OUT_W-1:0]    o_density_slope,
    output logic [1:0]                 o_region
);

    localparam int IDX_W = $clog2(KNOTS);

    // configuration registers
    logic [DIST_W-1:0]        r_inner_start;
    logic [DIST_W-1:0]        r_linear_start;
    logic [DIST_W-1:0]        r_cutoff;
    logic signed [WORD_W-1:0] r_linear_slope;
    logic signed [WORD_W-1:0] r_linear_offset;

    logic adv;

    // stage 0: accepted transaction
    logic                     r_s0_vld;
    t_cmd                     r_s0_cmd;
    logic [DIST_W-1:0]        r_s0_r;
    logic [IDX_W-1:0]         r_s0_idx;
    t_word_sel                r_s0_sel;
    logic signed [WORD_W-1:0] r_s0_word;

    logic [DIST_W-1:0]        r_knot [KNOTS];
    logic [KNOTS-1:0]         n_ge;
    logic [KNOTS-2:0]         n_match;
    logic [KNOTS-2:0]         n_first;
    logic [IDX_W-1:0]         n_seg;
    logic [DIST_W-1:0]        n_seg_knot;
    t_region                  n_region;
    logic signed [DX_W-1:0]   n_lin_d;
    logic                     n_addr_ok;
    logic                     n_knot_we;
    logic [3:0]               n_coef_we;
    logic signed [COEF_BITS-1:0] n_coef_wdata;

    // stage 1
    logic [DIST_W-1:0]           r_s1_r;
    logic [DIST_W-1:0]           r_s1_knot;
    logic signed [COEF_BITS-1:0] s1_coef [4];
    logic signed [DX_W-1:0]      n_dx;
    logic signed [COEF_BITS+1:0] n_c3x3;
    logic signed [COEF_BITS:0]   n_c2x2;

    // stage 2 and delay lines
    logic signed [COEF_BITS-1:0] r_s2_c3;
    logic signed [COEF_BITS-1:0] r_s2_c2;
    logic signed [COEF_BITS+1:0] r_s2_c3x3;
    logic signed [COEF_BITS:0]   r_s2_c2x2;
    logic signed [DX_W-1:0]      r_dx    [2:6];
    logic signed [COEF_BITS-1:0] r_c1    [2:4];
    logic signed [COEF_BITS-1:0] r_c0    [2:6];
    logic signed [DX_W-1:0]      r_lin_d [1:2];
    logic signed [ACC_W-1:0]     r_lin   [5:8];
    logic signed [ACC_W-1:0]     r_u2    [7:8];
    t_region                     r_region [1:8];
    logic [8:1]                  r_vld;

    logic signed [ACC_W-1:0] s4_t1;
    logic signed [ACC_W-1:0] s4_u1;
    logic signed [ACC_W-1:0] s4_lin;
    logic signed [ACC_W-1:0] s6_t2;
    logic signed [ACC_W-1:0] s6_u2;
    logic signed [ACC_W-1:0] s8_t3;

    // output register
    logic                     r_o_valid;
    logic signed [OUT_W-1:0]  r_o_density;
    logic signed [OUT_W-1:0]  r_o_slope;
    t_region                  r_o_region;
    logic signed [OUT_W-1:0]  n_o_density;
    logic signed [OUT_W-1:0]  n_o_slope;

    // Move the whole pipeline unless a finished result is held by the receiver
    assign adv     = !r_o_valid || !i_stall;
    assign o_stall = !adv;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inner_start   <= INNER_START_RST;
            r_linear_start  <= LINEAR_START_RST;
            r_cutoff        <= CUTOFF_RST;
            r_linear_slope  <= LINEAR_SLOPE_RST;
            r_linear_offset <= LINEAR_OFFSET_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_INNER_START:   r_inner_start   <= i_cfg_data[DIST_W-1:0];
                CFG_LINEAR_START:  r_linear_start  <= i_cfg_data[DIST_W-1:0];
                CFG_CUTOFF:        r_cutoff        <= i_cfg_data[DIST_W-1:0];
                CFG_LINEAR_SLOPE:  r_linear_slope  <= i_cfg_data;
                CFG_LINEAR_OFFSET: r_linear_offset <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Capture the accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
        end else if (adv) begin
            r_s0_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s0_cmd  <= t_cmd'(i_cmd);
            r_s0_r    <= i_distance;
            r_s0_idx  <= i_table_index;
            r_s0_sel  <= t_word_sel'(i_word_select);
            r_s0_word <= i_word_value;
        end
    end

    // Search the knots for the first segment holding r and classify the distance
    always_comb begin
        n_seg      = '0;
        n_seg_knot = '0;
        for (int i = 0; i < KNOTS; i++) begin
            n_ge[i] = r_knot[i] <= r_s0_r;
        end
        for (int i = 0; i < KNOTS - 1; i++) begin
            n_match[i] = n_ge[i] && !n_ge[i+1];
        end
        n_first = n_match & (~n_match + 1'b1);
        for (int i = 0; i < KNOTS - 1; i++) begin
            if (n_first[i]) begin
                n_seg      = n_seg | IDX_W'(i);
                n_seg_knot = n_seg_knot | r_knot[i];
            end
        end

        if (r_s0_r >= r_inner_start) begin
            if (r_s0_r <= r_cutoff && n_match != '0) begin
                n_region = REGION_SPLINE;
            end else begin
                n_region = REGION_BEYOND;
            end
        end else if (r_s0_r > r_linear_start) begin
            n_region = REGION_LINEAR;
        end else begin
            n_region = REGION_BELOW;
        end

        n_lin_d = $signed({1'b0, r_s0_r}) - $signed({1'b0, r_inner_start});
    end

    // Decode table writes
    always_comb begin
        n_addr_ok = r_s0_vld && (r_s0_cmd == CMD_WRITE)
                    && ({1'b0, r_s0_idx} < (IDX_W + 1)'(KNOTS));
        n_knot_we = 1'b0;
        n_coef_we = '0;
        unique case (r_s0_sel)
            WSEL_KNOT: n_knot_we    = n_addr_ok;
            WSEL_A:    n_coef_we[0] = n_addr_ok;
            WSEL_B:    n_coef_we[1] = n_addr_ok;
            WSEL_C:    n_coef_we[2] = n_addr_ok;
            WSEL_D:    n_coef_we[3] = n_addr_ok;
            default: ;
        endcase
    end

    generate
        if (COEF_BITS <= WORD_W) begin : g_coef_narrow
            assign n_coef_wdata = r_s0_word[COEF_BITS-1:0];
        end else begin : g_coef_wide
            assign n_coef_wdata = {{(COEF_BITS - WORD_W){r_s0_word[WORD_W-1]}}, r_s0_word};
        end
    endgenerate

    // Knot store
    always_ff @(posedge i_clk) begin
        if (adv && n_knot_we) begin
            r_knot[r_s0_idx] <= r_s0_word[DIST_W-1:0];
        end
    end

    // Coefficient RAMs, one per polynomial term, registered read at the segment index
    for (genvar k = 0; k < 4; k++) begin : g_coef
        logic signed [COEF_BITS-1:0] r_mem [KNOTS];
        logic signed [COEF_BITS-1:0] r_rd;

        always_ff @(posedge i_clk) begin
            if (adv && n_coef_we[k]) begin
                r_mem[r_s0_idx] <= n_coef_wdata;
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_rd <= r_mem[n_seg];
            end
        end

        assign s1_coef[k] = r_rd;
    end

    // Valid bits travel with the data; write transactions drop out here
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_o_valid <= 1'b0;
        end else if (adv) begin
            r_vld     <= {r_vld[7:1], r_s0_vld && (r_s0_cmd == CMD_EVAL)};
            r_o_valid <= r_vld[8];
        end
    end

    // Stage 1: offset within the segment and scaled derivative terms
    always_comb begin
        n_dx   = $signed({1'b0, r_s1_r - r_s1_knot});
        n_c3x3 = (COEF_BITS + 2)'(s1_coef[3]) + ((COEF_BITS + 2)'(s1_coef[3]) <<< 1);
        n_c2x2 = (COEF_BITS + 1)'(s1_coef[2]) <<< 1;
    end

    // Advance stage payloads and delay lines
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_r      <= r_s0_r;
            r_s1_knot   <= n_seg_knot;
            r_region[1] <= n_region;
            r_lin_d[1]  <= n_lin_d;
            for (int k = 2; k <= 8; k++) begin
                r_region[k] <= r_region[k-1];
            end

            r_s2_c3    <= s1_coef[3];
            r_s2_c2    <= s1_coef[2];
            r_s2_c3x3  <= n_c3x3;
            r_s2_c2x2  <= n_c2x2;
            r_lin_d[2] <= r_lin_d[1];

            r_dx[2] <= n_dx;
            for (int k = 3; k <= 6; k++) begin
                r_dx[k] <= r_dx[k-1];
            end
            r_c1[2] <= s1_coef[1];
            for (int k = 3; k <= 4; k++) begin
                r_c1[k] <= r_c1[k-1];
            end
            r_c0[2] <= s1_coef[0];
            for (int k = 3; k <= 6; k++) begin
                r_c0[k] <= r_c0[k-1];
            end

            r_lin[5] <= s4_lin;
            for (int k = 6; k <= 8; k++) begin
                r_lin[k] <= r_lin[k-1];
            end
            r_u2[7] <= s6_u2;
            r_u2[8] <= r_u2[7];
        end
    end

    // Density: d*dx + c, then *dx + b, then *dx + a
    dcs_horner_step #(.T_W(COEF_BITS), .C_W(COEF_BITS)) u_dens1 (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_t    (r_s2_c3),
        .i_coef (r_s2_c2),
        .i_dx   (r_dx[2]),
        .o_sum  (s4_t1)
    );

    dcs_horner_step #(.T_W(ACC_W), .C_W(COEF_BITS)) u_dens2 (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_t    (s4_t1),
        .i_coef (r_c1[4]),
        .i_dx   (r_dx[4]),
        .o_sum  (s6_t2)
    );

    dcs_horner_step #(.T_W(ACC_W), .C_W(COEF_BITS)) u_dens3 (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_t    (s6_t2),
        .i_coef (r_c0[6]),
        .i_dx   (r_dx[6]),
        .o_sum  (s8_t3)
    );

    // Slope: 3d*dx + 2c, then *dx + b
    dcs_horner_step #(.T_W(COEF_BITS + 2), .C_W(COEF_BITS + 1)) u_slope1 (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_t    (r_s2_c3x3),
        .i_coef (r_s2_c2x2),
        .i_dx   (r_dx[2]),
        .o_sum  (s4_u1)
    );

    dcs_horner_step #(.T_W(ACC_W), .C_W(COEF_BITS)) u_slope2 (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_t    (s4_u1),
        .i_coef (r_c1[4]),
        .i_dx   (r_dx[4]),
        .o_sum  (s6_u2)
    );

    // Linear near region: offset + slope*(r - inner_start)
    dcs_horner_step #(.T_W(WORD_W), .C_W(WORD_W)) u_linear (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_t    (r_linear_slope),
        .i_coef (r_linear_offset),
        .i_dx   (r_lin_d[2]),
        .o_sum  (s4_lin)
    );

    // Select the result by region and clamp to 32 bits
    always_comb begin
        unique case (r_region[8])
            REGION_SPLINE: begin
                n_o_density = sat_out(s8_t3);
                n_o_slope   = sat_out(r_u2[8]);
            end
            REGION_LINEAR: begin
                n_o_density = sat_out(r_lin[8]);
                n_o_slope   = r_linear_slope;
            end
            REGION_BELOW, REGION_BEYOND: begin
                n_o_density = '0;
                n_o_slope   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_o_density <= n_o_density;
            r_o_slope   <= n_o_slope;
            r_o_region  <= r_region[8];
        end
    end

    assign o_valid         = r_o_valid;
    assign o_density       = r_o_density;
    assign o_density_slope = r_o_slope;
    assign o_region        = 2'(r_o_region);

endmodule
